FILE: hdl/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64d_pkg
// Shared types and constants of the base64 picture stream decoder.
// ============================================================================
package b64d_pkg;

    localparam int PIC_LEN_W     = 15;
    localparam int WORD_W        = 24;
    localparam int QUEUE_DEPTH_D = 4;

    localparam logic [7:0] MARK_FIRST  = 8'hFF;
    localparam logic [7:0] MARK_SECOND = 8'hD9;

    // One queue entry: either a decoded quartet or a restart request that
    // must take effect in order behind the quartets already queued.
    typedef struct packed {
        logic                is_restart;
        logic [WORD_W-1:0]   word;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_status;

    typedef enum logic [1:0] {
        BYTE_HIGH = 2'd0,
        BYTE_MID  = 2'd1,
        BYTE_LOW  = 2'd2
    } t_byte_sel;

endpackage
`default_nettype wire

FILE: hdl/b64d_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64d_front
// Accepts characters, drops separators, gathers sextets into quartets.
// ============================================================================
module b64d_front
    import b64d_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_text_char,
    input  wire logic         i_restart,
    input  wire t_fifo_status i_status,
    output logic              o_push,
    output t_entry            o_entry
);

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    logic [17:0] r_bits, n_bits;
    logic [1:0]  r_count, n_count;
    logic        accept;
    logic        skip;
    logic [5:0]  sextet;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] s;
        s = 6'd0;
        case (c) inside
            [8'h41:8'h5A]: s = 6'(c - 8'h41);
            [8'h61:8'h7A]: s = 6'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: s = 6'(c - 8'h30 + 8'd52);
            8'h2B:         s = 6'd62;
            8'h2F:         s = 6'd63;
            default:       s = 6'd0;
        endcase
        return s;
    endfunction

    assign o_stall = i_status.full;
    assign accept  = i_valid && !o_stall;
    assign sextet  = sextet_of(i_text_char);

    always_comb begin
        skip = 1'b0;
        case (i_text_char) inside
            CH_SEMI, CH_SPACE, CH_CR, CH_LF: skip = 1'b1;
            default:                         skip = 1'b0;
        endcase
    end

    always_comb begin
        n_bits           = r_bits;
        n_count          = r_count;
        o_push           = 1'b0;
        o_entry.is_restart = 1'b0;
        o_entry.word     = {r_bits, sextet};
        if (accept) begin
            if (i_restart) begin
                n_bits             = '0;
                n_count            = '0;
                o_push             = 1'b1;
                o_entry.is_restart = 1'b1;
            end else if (!skip) begin
                if (r_count == 2'd3) begin
                    n_bits  = '0;
                    n_count = '0;
                    o_push  = 1'b1;
                end else begin
                    n_bits  = {r_bits[11:0], sextet};
                    n_count = r_count + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_count <= '0;
        end else begin
            r_bits  <= n_bits;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/b64d_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64d_fifo
// Short queue of decoded quartets and restart requests.
// ============================================================================
module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_D
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output t_fifo_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/b64d_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// b64d_back
// Splits queued quartets into bytes, applies length limit and end marker.
// ============================================================================
module b64d_back
    import b64d_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_entry               i_head,
    input  wire t_fifo_status         i_status,
    output logic                      o_pop,
    input  wire logic [PIC_LEN_W-1:0] i_pic_len,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_of_picture,
    output logic                      o_last_of_run
);

    t_byte_sel              r_sel, n_sel;
    logic [PIC_LEN_W-1:0]   r_emitted, n_emitted;
    logic [7:0]             r_prev, n_prev;
    logic                   r_end, n_end;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_byte, n_out_byte;
    logic                   r_out_pic, n_out_pic;
    logic                   r_out_run, n_out_run;

    logic                   slot_free;
    logic                   work;
    logic [7:0]             raw_byte;
    logic [7:0]             val;
    logic [PIC_LEN_W-1:0]   cnt_inc;
    logic                   reach;

    assign slot_free = !r_out_valid || !i_stall;
    assign work      = slot_free && !i_status.empty;
    assign cnt_inc   = r_emitted + PIC_LEN_W'(1);
    assign reach     = (cnt_inc == i_pic_len);
    assign val       = r_end ? 8'h00 : raw_byte;

    always_comb begin
        case (r_sel)
            BYTE_HIGH: raw_byte = i_head.word[23:16];
            BYTE_MID:  raw_byte = i_head.word[15:8];
            BYTE_LOW:  raw_byte = i_head.word[7:0];
            default:   raw_byte = i_head.word[7:0];
        endcase
    end

    always_comb begin
        n_sel       = r_sel;
        n_emitted   = r_emitted;
        n_prev      = r_prev;
        n_end       = r_end;
        n_out_valid = r_out_valid && i_stall;
        n_out_byte  = r_out_byte;
        n_out_pic   = r_out_pic;
        n_out_run   = r_out_run;
        o_pop       = 1'b0;
        if (work) begin
            if (i_head.is_restart) begin
                n_sel     = BYTE_HIGH;
                n_emitted = '0;
                n_prev    = '0;
                n_end     = 1'b0;
                o_pop     = 1'b1;
            end else if (r_emitted >= i_pic_len) begin
                // Length already reached: the quartet is dropped whole.
                n_sel = BYTE_HIGH;
                o_pop = 1'b1;
            end else begin
                n_out_valid = 1'b1;
                n_out_byte  = val;
                n_out_pic   = reach;
                n_out_run   = reach || (r_sel == BYTE_LOW);
                n_emitted   = cnt_inc;
                n_prev      = val;
                n_end       = r_end || (r_prev == MARK_FIRST && val == MARK_SECOND);
                if (reach || r_sel == BYTE_LOW) begin
                    n_sel = BYTE_HIGH;
                    o_pop = 1'b1;
                end else if (r_sel == BYTE_HIGH) begin
                    n_sel = BYTE_MID;
                end else begin
                    n_sel = BYTE_LOW;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= BYTE_HIGH;
            r_emitted   <= '0;
            r_prev      <= '0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sel       <= n_sel;
            r_emitted   <= n_emitted;
            r_prev      <= n_prev;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_pic  <= n_out_pic;
        r_out_run  <= n_out_run;
    end

    assign o_valid           = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_last_of_picture = r_out_pic;
    assign o_last_of_run     = r_out_run;

`ifndef ASSERT_OFF
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3)
        else $error("byte selector left its range");

    a_pic_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pic) |-> r_out_run)
        else $error("last byte of picture not flagged as last of run");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (work && i_head.is_restart) |=> (r_emitted == '0 && !r_end && r_sel == BYTE_HIGH))
        else $error("restart did not clear picture state");
`endif

endmodule
`default_nettype wire

FILE: hdl/base64_jpeg_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// base64_jpeg_stream_decoder
// Streams base64 picture text into bytes, limited to a configured length.
// ============================================================================
//
//  Channel   Direction  Handshake                Payload
//  -------   ---------  -----------------------  -----------------------------
//  input     in         i_valid / o_stall        i_text_char, i_restart
//  output    out        o_valid / i_stall        o_out_byte, o_last_of_picture,
//                                                o_last_of_run
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (picture length)
//
// One character is taken per cycle while the queue is not full. Each completed
// quartet yields up to three bytes, which the back end sends one per cycle from
// its output register while the output is not stalled.
// Reset is synchronous and active low and clears all control state and the
// picture length; there is no clearing pass.
// The queue between front and back (QUEUE_DEPTH entries) absorbs a stalled
// output; the input stalls only while that queue is full.
// A restart transfer travels through the queue, so it takes effect in order
// behind the quartets already decoded.
//
module base64_jpeg_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [7:0]           i_text_char,
    input  wire logic                 i_restart,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_of_picture,
    output logic                      o_last_of_run,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [PIC_LEN_W-1:0] i_cfg_data
);

    logic [PIC_LEN_W-1:0] r_pic_len;
    logic                 push;
    logic                 pop;
    t_entry               push_entry;
    t_entry               head;
    t_fifo_status         status;

    // The length register is always ready; the user must write it only while idle, the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pic_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pic_len <= i_cfg_data;
        end
    end

    // Front end: classifies characters and assembles quartets.
    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_char (i_text_char),
        .i_restart   (i_restart),
        .i_status    (status),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // Queue decoupling the two sides.
    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    // Back end: byte emission, length limit and end-marker blanking.
    b64d_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .i_status          (status),
        .o_pop             (pop),
        .i_pic_len         (r_pic_len),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_byte        (o_out_byte),
        .o_last_of_picture (o_last_of_picture),
        .o_last_of_run     (o_last_of_run)
    );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives base64 text into the picture stream decoder and checks every
// decoded byte and its flags against a behavioral model of the quartet
// decoding, the picture length limit and the end-marker zeroing.
// ============================================================================
module testbench
    import b64d_pkg::*;
();

    // Characters with a meaning of their own in the text stream.
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    localparam logic [PIC_LEN_W-1:0] LEN_MAX = 15'd24500;

    localparam int SETTLE_CYCLES   = 32;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int HOLD_CYCLES     = 120;
    localparam int REPORT_LIMIT    = 10;
    localparam int ITEMS_PER_PHASE = 24;
    localparam int RANDOM_PHASES   = 8;
    localparam int DIRECTED_ROWS   = 31;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       pic_last;
        logic       run_last;
    } t_byte_result;

    // One row of text stimulus. A row may instead carry a picture length
    // write, and a text row may carry its expected bytes typed in by hand.
    typedef struct packed {
        logic                 is_len_write;
        logic [PIC_LEN_W-1:0] new_len;
        logic [7:0]           ch;
        logic                 restart;
        logic                 has_fixed;
        logic [1:0]           fixed_count;
        logic [23:0]          fixed_bytes;
        logic [2:0]           fixed_pic_last;
    } t_text_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_text_char = 8'h00;
    logic                 i_restart   = 1'b0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_last_of_picture;
    logic                 o_last_of_run;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [PIC_LEN_W-1:0] i_cfg_data  = '0;

    base64_jpeg_stream_decoder i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_text_char       (i_text_char),
        .i_restart         (i_restart),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_byte        (o_out_byte),
        .o_last_of_picture (o_last_of_picture),
        .o_last_of_run     (o_last_of_run),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Decoder state as the block should hold it.
    logic [17:0]          dec_bits      = '0;
    logic [1:0]           dec_count     = '0;
    logic [PIC_LEN_W-1:0] dec_emitted   = '0;
    logic [7:0]           dec_prev_byte = '0;
    logic                 dec_end_seen  = 1'b0;
    logic [PIC_LEN_W-1:0] pic_length    = '0;

    t_text_item   pending_text[$];
    t_byte_result expected_bytes[$];

    int  failures        = 0;
    int  bytes_checked   = 0;
    int  text_transfers  = 0;
    int  restarts_sent   = 0;
    int  markers_found   = 0;
    int  length_settings = 0;
    int  holds_requested = 0;
    bit  sender_steady   = 1'b0;

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] v;
        if (c >= "A" && c <= "Z") begin
            v = c - "A";
        end else if (c >= "a" && c <= "z") begin
            v = c - "a" + 8'd26;
        end else if (c >= "0" && c <= "9") begin
            v = c - "0" + 8'd52;
        end else if (c == "+") begin
            v = 8'd62;
        end else if (c == "/") begin
            v = 8'd63;
        end else begin
            // Padding and anything outside the alphabet count as zero.
            v = 8'd0;
        end
        return v[5:0];
    endfunction

    // Advances the decoder state by one accepted text transfer and, when
    // asked, queues the bytes that it causes.
    task automatic decode_char(input logic [7:0] c, input logic rst, input bit keep);
        logic [23:0]  word;
        logic [7:0]   v;
        int           room;
        int           n_out;
        t_byte_result r;
        if (rst) begin
            dec_bits      = '0;
            dec_count     = '0;
            dec_emitted   = '0;
            dec_prev_byte = '0;
            dec_end_seen  = 1'b0;
        end else if (c == CH_SEMI || c == CH_SPACE || c == CH_CR || c == CH_LF) begin
            // Separators are dropped without touching the quartet.
        end else if (dec_count != 2'd3) begin
            dec_bits  = {dec_bits[11:0], char_to_sextet(c)};
            dec_count = dec_count + 2'd1;
        end else begin
            word      = {dec_bits, char_to_sextet(c)};
            dec_bits  = '0;
            dec_count = '0;
            // The quartet is always decoded, but only the bytes that fit in
            // the picture are sent.
            room  = int'(pic_length) - int'(dec_emitted);
            n_out = (room <= 0) ? 0 : ((room > 3) ? 3 : room);
            for (int k = 0; k < n_out; k++) begin
                v = dec_end_seen ? 8'h00 : word[23 - 8*k -: 8];
                if (dec_prev_byte == MARK_FIRST && v == MARK_SECOND) begin
                    dec_end_seen = 1'b1;
                    markers_found++;
                end
                dec_prev_byte = v;
                dec_emitted   = dec_emitted + 1'b1;
                r.data     = v;
                r.pic_last = (dec_emitted == pic_length);
                r.run_last = (k == n_out - 1);
                if (keep) expected_bytes.push_back(r);
            end
        end
    endtask

    function automatic t_text_item text_item(input logic [7:0] ch, input logic rst);
        t_text_item it;
        it         = '0;
        it.ch      = ch;
        it.restart = rst;
        return it;
    endfunction

    function automatic t_text_item fixed_item(input logic [7:0] ch, input logic rst,
                                              input logic [1:0] count,
                                              input logic [23:0] bytes,
                                              input logic [2:0] pic_last);
        t_text_item it;
        it                = text_item(ch, rst);
        it.has_fixed      = 1'b1;
        it.fixed_count    = count;
        it.fixed_bytes    = bytes;
        it.fixed_pic_last = pic_last;
        return it;
    endfunction

    function automatic t_text_item len_item(input logic [PIC_LEN_W-1:0] len);
        t_text_item it;
        it              = '0;
        it.is_len_write = 1'b1;
        it.new_len      = len;
        return it;
    endfunction

    // Directed stimulus, one row per transfer or length write.
    function automatic t_text_item directed_row(input int idx);
        t_text_item it;
        case (idx)
            // Length zero: a full quartet must send nothing.
            0:  it = len_item('0);
            1:  it = text_item("Q", 1'b0);
            2:  it = text_item("U", 1'b0);
            3:  it = text_item("J", 1'b0);
            4:  it = fixed_item("D", 1'b0, 2'd0, 24'h000000, 3'b000);
            5:  it = len_item(15'd10);
            6:  it = fixed_item(8'hA5, 1'b1, 2'd0, 24'h000000, 3'b000);
            // D9 right after restart is not an end marker.
            7:  it = text_item("2", 1'b0);
            8:  it = text_item("Q", 1'b0);
            9:  it = text_item("A", 1'b0);
            10: it = fixed_item("A", 1'b0, 2'd3, 24'hD90000, 3'b000);
            // All ones, with every separator in between.
            11: it = text_item("/", 1'b0);
            12: it = text_item(CH_SEMI, 1'b0);
            13: it = text_item("/", 1'b0);
            14: it = text_item(CH_SPACE, 1'b0);
            15: it = text_item(CH_CR, 1'b0);
            16: it = text_item("/", 1'b0);
            17: it = text_item(CH_LF, 1'b0);
            18: it = text_item("/", 1'b0);
            // Padded quartet that completes FF D9; later bytes turn to zero.
            19: it = text_item("2", 1'b0);
            20: it = text_item("Q", 1'b0);
            21: it = text_item(CH_PAD, 1'b0);
            22: it = text_item(CH_PAD, 1'b0);
            // Invalid characters at both ends of the range; reaches length.
            23: it = text_item(8'h00, 1'b0);
            24: it = text_item(8'hFF, 1'b0);
            25: it = text_item("z", 1'b0);
            26: it = text_item("9", 1'b0);
            // Past the length: decoded but dropped.
            27: it = text_item("+", 1'b0);
            28: it = text_item("/", 1'b0);
            29: it = text_item("+", 1'b0);
            default: it = text_item("/", 1'b0);
        endcase
        return it;
    endfunction

    function automatic logic [7:0] random_b64_char();
        logic [7:0] idx;
        logic [7:0] ch;
        idx = 8'($urandom_range(0, 63));
        if (idx < 8'd26) begin
            ch = "A" + idx;
        end else if (idx < 8'd52) begin
            ch = "a" + idx - 8'd26;
        end else if (idx < 8'd62) begin
            ch = "0" + idx - 8'd52;
        end else if (idx == 8'd62) begin
            ch = "+";
        end else begin
            ch = "/";
        end
        return ch;
    endfunction

    // Mostly well-formed quartets with random content and stray separators,
    // with some loose characters that shift the quartet alignment and some
    // restarts in the middle of a picture.
    task automatic queue_random_text(input int n_items);
        int          made;
        int          roll;
        logic [31:0] quad;
        logic [7:0]  sep;
        made = 0;
        while (made < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                pending_text.push_back(text_item(8'($urandom_range(0, 255)), 1'b1));
                made++;
            end else if (roll < 8) begin
                pending_text.push_back(text_item(8'($urandom_range(0, 255)), 1'b0));
                made++;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    quad = "/9kA";
                end else if (roll < 20) begin
                    quad = "///Z";
                end else if (roll < 25) begin
                    quad = "2QAA";
                end else begin
                    quad = {random_b64_char(), random_b64_char(),
                            random_b64_char(), random_b64_char()};
                    if (roll < 32) begin
                        quad[7:0] = CH_PAD;
                    end else if (roll < 38) begin
                        quad[15:0] = {CH_PAD, CH_PAD};
                    end
                end
                for (int p = 3; p >= 0; p--) begin
                    if ($urandom_range(0, 9) == 0) begin
                        case ($urandom_range(0, 3))
                            0:       sep = CH_SEMI;
                            1:       sep = CH_SPACE;
                            2:       sep = CH_CR;
                            default: sep = CH_LF;
                        endcase
                        pending_text.push_back(text_item(sep, 1'b0));
                    end
                    pending_text.push_back(text_item(quad[8*p +: 8], 1'b0));
                    made++;
                end
            end
        end
    endtask

    task automatic report_failure(input string what, input t_byte_result want,
                                  input t_byte_result got, input bit have_want);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            if (have_want) begin
                $display("%s at %0t: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                         what, $realtime, want.data, want.pic_last, want.run_last,
                         got.data, got.pic_last, got.run_last);
            end else begin
                $display("%s at %0t: got %02h/%0b/%0b", what, $realtime,
                         got.data, got.pic_last, got.run_last);
            end
        end
    endtask

    // Waits until the block is idle, then writes the picture length. The
    // settle stretch covers quartets that are still in flight but send
    // nothing.
    task automatic write_picture_length(input logic [PIC_LEN_W-1:0] len);
        while (pending_text.size() != 0) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pic_length = len;
        length_settings++;
    endtask

    // Text sender: bursts of random length separated by random gaps. A
    // stalled transfer holds its payload until it is taken.
    initial begin : text_sender
        int           burst_left;
        int           gap_left;
        t_text_item   head;
        t_byte_result r;
        burst_left = 0;
        gap_left   = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_valid && !o_stall) begin
                head = pending_text.pop_front();
                text_transfers++;
                if (head.restart) restarts_sent++;
                if (head.has_fixed) begin
                    decode_char(head.ch, head.restart, 1'b0);
                    for (int k = 0; k < int'(head.fixed_count); k++) begin
                        r.data     = head.fixed_bytes[23 - 8*k -: 8];
                        r.pic_last = head.fixed_pic_last[2 - k];
                        r.run_last = (k == int'(head.fixed_count) - 1);
                        expected_bytes.push_back(r);
                    end
                end else begin
                    decode_char(head.ch, head.restart, 1'b1);
                end
                burst_left--;
            end
            if (!(i_valid && o_stall)) begin
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    if (sender_steady || $urandom_range(0, 2) == 0) begin
                        gap_left = 0;
                    end else begin
                        gap_left = $urandom_range(1, 6);
                    end
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_text.size() != 0) begin
                    i_valid     <= 1'b1;
                    i_text_char <= pending_text[0].ch;
                    i_restart   <= pending_text[0].restart;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Byte receiver: changes its stall pattern whenever the current mode runs out and
    // holds off completely for a long stretch when one is requested.
    initial begin : byte_receiver
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          holds_served;
        int          tick;
        int          period;
        mode         = STALL_NONE;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        tick         = 0;
        period       = 4;
        forever begin
            @(posedge i_clk);
            if (holds_requested > holds_served) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left <= 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 160);
                period    = $urandom_range(2, 7);
            end
            mode_left--;
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:     i_stall <= 1'b0;
                    STALL_SPARSE:   i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PERIODIC: i_stall <= ((tick % period) == 0);
                    default:        i_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Each byte transfer is compared with the oldest expected byte.
    always @(posedge i_clk) begin : byte_check
        t_byte_result got;
        t_byte_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_out_byte, o_last_of_picture, o_last_of_run};
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                report_failure("Unexpected byte", got, got, 1'b0);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want) report_failure("Byte mismatch", want, got, 1'b1);
            end
        end
    end

    initial begin : run_limit
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : main_sequence
        t_text_item           row;
        logic [PIC_LEN_W-1:0] len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int idx = 0; idx < DIRECTED_ROWS; idx++) begin
            row = directed_row(idx);
            if (row.is_len_write) begin
                write_picture_length(row.new_len);
            end else begin
                pending_text.push_back(row);
            end
        end

        // Random pictures under several lengths. One phase lowers the
        // length without a restart, so a picture already under way stops.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       len = LEN_MAX;
                1:       len = 15'd1;
                3:       len = 15'd3;
                4:       len = LEN_MAX;
                5:       len = '0;
                6:       len = 15'd2;
                default: len = PIC_LEN_W'($urandom_range(4, 60));
            endcase
            write_picture_length(len);
            if (ph != 5) pending_text.push_back(text_item(8'($urandom_range(0, 255)), 1'b1));
            // In the long picture the sender keeps offering while the
            // receiver holds off, so the internal queue fills up.
            sender_steady = (ph == 4);
            if (ph == 4) holds_requested++;
            queue_random_text(ITEMS_PER_PHASE);
        end

        while (pending_text.size() != 0) @(posedge i_clk);
        for (int w = 0; w < DRAIN_LIMIT && expected_bytes.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            failures += expected_bytes.size();
            $display("%0d expected bytes never arrived", expected_bytes.size());
        end

        $display("Sent %0d text transfers, %0d of them restarts, under %0d length settings.",
                 text_transfers, restarts_sent, length_settings);
        $display("Compared %0d decoded bytes, saw %0d end markers, %0d failures.",
                 bytes_checked, markers_found, failures);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
